>>> design/scd_pkg.sv
`timescale 1ns / 1ps
package scd_pkg;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic REG_DECAY = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	// exp(-1) as Q2.30, from the same truncated series as the fraction path
	localparam logic [28:0] E1_Q30  = 29'd395007543;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	localparam logic signed [62:0] POT_MAX = 63'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [62:0] POT_MIN = -63'sh0000_8000_0000_0000;

	localparam logic [5:0] DIV_STEPS_SHORT = 6'd31;
	localparam logic [5:0] DIV_STEPS_LONG  = 6'd62;
	localparam logic [5:0] SQRT_STEPS      = 6'd32;
	localparam logic [4:0] SERIES_LAST     = 5'd16;

	typedef enum logic [4:0] {
		S_IDLE, S_LATI, S_NEXT, S_LATJ, S_MULX, S_MULY, S_MULZ, S_SUMZ,
		S_SQRT, S_RCHK, S_TADD, S_EINIT, S_EMUL, S_EDIV, S_EWAIT, S_ECLAMP,
		S_EPOW, S_PSHIFT, S_WDIV, S_WWAIT, S_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_QSTART, OP_LATI, OP_READJ, OP_SKIP, OP_LATJ,
		OP_MULX, OP_MULY, OP_MULZ, OP_SUMZ, OP_SQRT, OP_RZERO, OP_TMUL,
		OP_TADD, OP_EINIT, OP_EMUL, OP_EDIV, OP_EACC, OP_ECLAMP, OP_PMUL,
		OP_PSHIFT, OP_WMUL, OP_WDIV, OP_ACC
	} dp_op_t;

	typedef struct packed {
		logic idx_bad;
		logic j_end;
		logic j_self;
		logic sq_last;
		logic r_zero;
		logic n_big;
		logic n_zero;
		logic k_last;
		logic div_done;
	} dp_stat_t;

endpackage

>>> design/scd_div.sv
`timescale 1ns / 1ps
module scd_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [61:0] dividend,
	input  logic [38:0] divisor,
	input  logic [5:0]  steps,
	output logic [61:0] quotient,
	output logic        done
);
	import scd_pkg::*;

	logic [39:0] rem_q;
	logic [61:0] dq_q;
	logic [38:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic [39:0] rem_n;
	logic        fits;

	always_comb begin
		rem_n = {rem_q[38:0], dq_q[61]};
		fits  = rem_n >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= steps;
			end else if (cnt_q != 6'd0) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != 6'd0) begin
			rem_q <= fits ? (rem_n - {1'b0, dvs_q}) : rem_n;
			dq_q  <= {dq_q[60:0], fits};
		end
	end

	assign quotient = dq_q;
	assign done     = done_q;
endmodule

>>> design/scd_datapath.sv
`timescale 1ns / 1ps
module scd_datapath #(
	parameter int MAX_POINTS = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  scd_pkg::dp_op_t    op,
	output scd_pkg::dp_stat_t  stat,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic [11:0]        point_index,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic signed [31:0] weight,
	output logic signed [47:0] potential,
	output logic               saturated
);
	import scd_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int PW = (CW > 13) ? CW : 13;

	logic [127:0] mem [MAX_POINTS];
	logic [127:0] rdata_q;
	logic [AW-1:0] raddr;

	logic [23:0] decay_q;
	logic [12:0] count_q;
	logic [PW-1:0] idx_ext, count_lim;
	logic [AW-1:0] idx_q;
	logic [PW-1:0] j_q;

	logic [31:0] xi_q, yi_q, zi_q;
	logic [31:0] ax_q, ay_q, az_q, wmag_q;
	logic        wneg_q;
	logic [63:0] prod_q;
	logic [31:0] mul_a, mul_b;
	logic [65:0] sum_q;
	logic [35:0] rem_q;
	logic [32:0] root_q;
	logic [5:0]  sq_cnt_q;
	logic [35:0] rem_n, trial;
	logic [56:0] t_q;
	logic [29:0] x_q;
	logic [30:0] term_q;
	logic signed [32:0] acce_q;
	logic [4:0]  k_q, n_q;
	logic [30:0] e_q;
	logic signed [47:0] acc_q;
	logic        flag_q;

	logic        div_start, div_done;
	logic [61:0] div_dividend, div_q;
	logic [38:0] div_divisor;
	logic [5:0]  div_steps;

	logic [31:0] jx, jy, jz, jw;
	logic [32:0] dxs, dys, dzs, dxn, dyn, dzn;
	logic signed [62:0] term63, sum63;
	logic signed [32:0] eterm;

	function automatic logic [32:0] sdiff(input logic [31:0] a, input logic [31:0] b);
		sdiff = {a[31], a} - {b[31], b};
	endfunction

	assign idx_ext   = PW'(point_index);
	assign count_lim = (PW'(count_q) > PW'(MAX_POINTS)) ? PW'(MAX_POINTS) : PW'(count_q);
	assign {jx, jy, jz, jw} = rdata_q;

	assign stat.idx_bad  = idx_ext >= PW'(MAX_POINTS);
	assign stat.j_end    = j_q >= count_lim;
	assign stat.j_self   = j_q == PW'(idx_q);
	assign stat.sq_last  = sq_cnt_q == 6'd0;
	assign stat.r_zero   = root_q == 33'd0;
	assign stat.n_big    = |t_q[56:37];
	assign stat.n_zero   = n_q == 5'd0;
	assign stat.k_last   = k_q == SERIES_LAST;
	assign stat.div_done = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= '0;
			count_q <= 13'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DECAY: decay_q <= cfg_data;
				REG_COUNT: count_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	assign raddr = (op == OP_QSTART) ? idx_ext[AW-1:0] : j_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (op == OP_LOAD && !stat.idx_bad) begin
			mem[idx_ext[AW-1:0]] <= {coord_x, coord_y, coord_z, weight};
		end
		rdata_q <= mem[raddr];
	end

	// shared 32x32 multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op)
			OP_MULX: begin mul_a = ax_q; mul_b = ax_q; end
			OP_MULY: begin mul_a = ay_q; mul_b = ay_q; end
			OP_MULZ: begin mul_a = az_q; mul_b = az_q; end
			OP_TMUL: begin mul_a = {8'd0, decay_q}; mul_b = root_q[31:0]; end
			OP_EMUL: begin mul_a = {1'b0, term_q}; mul_b = {2'd0, x_q}; end
			OP_PMUL: begin mul_a = {1'b0, e_q}; mul_b = {3'd0, E1_Q30}; end
			OP_WMUL: begin mul_a = wmag_q; mul_b = {1'b0, e_q}; end
			default: ;
		endcase
	end

	always_comb begin
		rem_n = {rem_q[33:0], sum_q[65:64]};
		trial = {1'b0, root_q, 2'b01};
		dxs = sdiff(xi_q, jx);
		dys = sdiff(yi_q, jy);
		dzs = sdiff(zi_q, jz);
		dxn = -dxs;
		dyn = -dys;
		dzn = -dzs;
		eterm  = {2'b00, div_q[30:0]};
		term63 = wneg_q ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
		sum63  = {{15{acc_q[47]}}, acc_q} + term63;
	end

	assign div_start    = (op == OP_EDIV) || (op == OP_WDIV);
	assign div_dividend = (op == OP_EDIV) ? {prod_q[60:30], 31'd0} : prod_q[61:0];
	assign div_divisor  = (op == OP_EDIV) ? {34'd0, k_q} : {root_q, 6'd0};
	assign div_steps    = (op == OP_EDIV) ? DIV_STEPS_SHORT : DIV_STEPS_LONG;

	scd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.steps    (div_steps),
		.quotient (div_q),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q <= '0;
		end else begin
			case (op)
				OP_QSTART:                 j_q <= '0;
				OP_SKIP, OP_RZERO, OP_ACC: j_q <= j_q + PW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mul_a != 32'd0 || op == OP_MULX || op == OP_MULY || op == OP_MULZ ||
		    op == OP_TMUL || op == OP_EMUL || op == OP_PMUL || op == OP_WMUL) begin
			prod_q <= mul_a * mul_b;
		end
		case (op)
			OP_QSTART: begin
				idx_q  <= idx_ext[AW-1:0];
				acc_q  <= '0;
				flag_q <= 1'b0;
			end
			OP_LATI: begin
				xi_q <= jx;
				yi_q <= jy;
				zi_q <= jz;
			end
			OP_LATJ: begin
				ax_q   <= dxs[32] ? dxn[31:0] : dxs[31:0];
				ay_q   <= dys[32] ? dyn[31:0] : dys[31:0];
				az_q   <= dzs[32] ? dzn[31:0] : dzs[31:0];
				wneg_q <= jw[31];
				wmag_q <= jw[31] ? (32'd0 - jw) : jw;
				sum_q  <= '0;
			end
			OP_MULY, OP_MULZ: sum_q <= sum_q + {2'b00, prod_q};
			OP_SUMZ: begin
				sum_q    <= sum_q + {2'b00, prod_q};
				rem_q    <= '0;
				root_q   <= '0;
				sq_cnt_q <= SQRT_STEPS;
			end
			OP_SQRT: begin
				// one root bit per cycle, top bit pair first
				if (rem_n >= trial) begin
					rem_q  <= rem_n - trial;
					root_q <= {root_q[31:0], 1'b1};
				end else begin
					rem_q  <= rem_n;
					root_q <= {root_q[31:0], 1'b0};
				end
				sum_q    <= {sum_q[63:0], 2'b00};
				sq_cnt_q <= sq_cnt_q - 6'd1;
			end
			OP_RZERO: flag_q <= 1'b1;
			OP_TADD: t_q <= {1'b0, prod_q[55:0]}
				+ (root_q[32] ? {1'b0, decay_q, 32'd0} : 57'd0);
			OP_EINIT: begin
				x_q    <= t_q[31:2];
				n_q    <= t_q[36:32];
				term_q <= ONE_Q30;
				acce_q <= {2'b00, ONE_Q30};
				k_q    <= 5'd1;
			end
			OP_EACC: begin
				term_q <= div_q[30:0];
				acce_q <= k_q[0] ? (acce_q - eterm) : (acce_q + eterm);
				k_q    <= k_q + 5'd1;
			end
			OP_ECLAMP: e_q <= acce_q[32] ? 31'd0 : acce_q[30:0];
			OP_PSHIFT: begin
				e_q <= prod_q[60:30];
				n_q <= n_q - 5'd1;
			end
			OP_ACC: begin
				if (sum63 > POT_MAX) begin
					acc_q  <= POT_MAX[47:0];
					flag_q <= 1'b1;
				end else if (sum63 < POT_MIN) begin
					acc_q  <= POT_MIN[47:0];
					flag_q <= 1'b1;
				end else begin
					acc_q <= sum63[47:0];
				end
			end
			default: ;
		endcase
	end

	assign potential = acc_q;
	assign saturated = flag_q;
endmodule

>>> design/scd_ctrl.sv
`timescale 1ns / 1ps
module scd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              cmd,
	input  scd_pkg::dp_stat_t stat,
	output scd_pkg::dp_op_t   op,
	output logic              busy,
	output logic              done
);
	import scd_pkg::*;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		op      = OP_NONE;
		busy    = state_q != S_IDLE;
		done    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (cmd == CMD_LOAD) begin
						op = OP_LOAD;
					end else begin
						op      = OP_QSTART;
						state_n = stat.idx_bad ? S_DONE : S_LATI;
					end
				end
			end
			S_LATI: begin
				op      = OP_LATI;
				state_n = S_NEXT;
			end
			S_NEXT: begin
				if (stat.j_end) begin
					state_n = S_DONE;
				end else if (stat.j_self) begin
					op = OP_SKIP;
				end else begin
					op      = OP_READJ;
					state_n = S_LATJ;
				end
			end
			S_LATJ: begin op = OP_LATJ; state_n = S_MULX; end
			S_MULX: begin op = OP_MULX; state_n = S_MULY; end
			S_MULY: begin op = OP_MULY; state_n = S_MULZ; end
			S_MULZ: begin op = OP_MULZ; state_n = S_SUMZ; end
			S_SUMZ: begin op = OP_SUMZ; state_n = S_SQRT; end
			S_SQRT: begin
				op = OP_SQRT;
				if (stat.sq_last) begin
					state_n = S_RCHK;
				end
			end
			S_RCHK: begin
				// coincident point: flag it and add nothing
				if (stat.r_zero) begin
					op      = OP_RZERO;
					state_n = S_NEXT;
				end else begin
					op      = OP_TMUL;
					state_n = S_TADD;
				end
			end
			S_TADD: begin op = OP_TADD; state_n = S_EINIT; end
			S_EINIT: begin
				if (stat.n_big) begin
					op      = OP_SKIP;
					state_n = S_NEXT;
				end else begin
					op      = OP_EINIT;
					state_n = S_EMUL;
				end
			end
			S_EMUL: begin op = OP_EMUL; state_n = S_EDIV; end
			S_EDIV: begin op = OP_EDIV; state_n = S_EWAIT; end
			S_EWAIT: begin
				if (stat.div_done) begin
					op      = OP_EACC;
					state_n = stat.k_last ? S_ECLAMP : S_EMUL;
				end
			end
			S_ECLAMP: begin op = OP_ECLAMP; state_n = S_EPOW; end
			S_EPOW: begin
				if (stat.n_zero) begin
					op      = OP_WMUL;
					state_n = S_WDIV;
				end else begin
					op      = OP_PMUL;
					state_n = S_PSHIFT;
				end
			end
			S_PSHIFT: begin op = OP_PSHIFT; state_n = S_EPOW; end
			S_WDIV: begin op = OP_WDIV; state_n = S_WWAIT; end
			S_WWAIT: begin
				if (stat.div_done) begin
					op      = OP_ACC;
					state_n = S_NEXT;
				end
			end
			S_DONE: begin
				done    = 1'b1;
				state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end
endmodule

>>> design/screened_coulomb_direct_sum.sv
`timescale 1ns / 1ps
// Screened Coulomb potential by direct summation over a store of points.
// Command channel: an item is taken on a clock edge with start high and
// busy low. cmd selects load (write x, y, z, weight at point_index) or
// query (sum the potential at the stored point point_index).
// A load writes the store and gives no result; busy stays low.
// A query raises busy and walks entries 0..point_count-1 (at most
// MAX_POINTS) one at a time; an out-of-range point_index ends it at once.
// The queried entry is skipped; every other entry goes through the
// sequencer: fetch, squares, square root, a 16-term series where each
// term waits on the shared bit-serial divider, a multiply by exp(-1) for
// each unit of the integer part n of the exponent and a final division by
// the distance. A coincident point adds nothing and sets saturated; one
// whose exponent is 32 or more is skipped. The result sits on potential
// and saturated while done is high, for exactly one cycle; the receiver
// cannot stall it. busy falls after it. Configuration (cfg_we, cfg_index,
// cfg_data) is for the user to write only while idle; the block does not enforce this.
// Reset clears the sequencer and the registers (decay_rate 0, point_count 1);
// the point store is not cleared and must be loaded before use.
module screened_coulomb_direct_sum #(
	parameter int MAX_POINTS = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cmd,
	input  logic [11:0]        point_index,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic signed [31:0] weight,
	output logic               done,
	output logic signed [47:0] potential,
	output logic               saturated,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [23:0]        cfg_data
);
	import scd_pkg::*;

	dp_op_t   op;
	dp_stat_t stat;

	scd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.stat   (stat),
		.op     (op),
		.busy   (busy),
		.done   (done)
	);

	scd_datapath #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.point_index (point_index),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.coord_z     (coord_z),
		.weight      (weight),
		.potential   (potential),
		.saturated   (saturated)
	);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe outside a query");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == CMD_LOAD) |=> !done)
		else $error("load item gave a result");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held");

	a_idle_after: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy held after result");
endmodule
